>>> rtl/ntm_pkg.sv
// shared types and codes of the nfa token matcher
package ntm_pkg;

    localparam int NUM_STATES_W = 5;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_FEED  = 2'd2
    } op_code_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] symbol;
        logic [3:0] from_state;
        logic [3:0] to_state;
    } in_word_t;

    typedef struct packed {
        logic alive;
        logic accepted;
    } out_word_t;

    typedef struct packed {
        logic rd_en;
        logic set_en;
    } store_op_t;

endpackage

>>> rtl/nfa_token_matcher.sv
// nfa token matcher top level: control sequencer, active set and output register
//
// input channel in_valid/in_stall carries in_word (operation, symbol, from_state,
// to_state); output channel out_valid/out_stall carries out_word (alive, accepted).
// a word moves at a rising edge with valid high and stall low.
// cfg_wr_en/cfg_wr_data write num_states, taken at any edge with cfg_wr_en high.
// one word is worked on at a time; in_stall is low only when the sequencer is idle.
// load edge: read the mask, then write it back with the new bit; no result.
// start: goes through ST_FIN to the output register.
// feed: ST_FEED, ST_FEED_END, then ST_FIN to the output register; the single read
// port of the transition store is swept once per state in use. a feed while the
// run is dead goes straight to ST_FIN.
// after reset the store is cleared one entry a cycle over all NUM_STATES << SYMBOL_BITS
// entries (4096 by default), while in_stall stays high; cfg writes are still taken.
// while the receiver stalls, the result waits in the output register and the
// next word finishes its work but holds its result until the register drains.
module nfa_token_matcher #(
    parameter int NUM_STATES  = 16,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  ntm_pkg::in_word_t                    in_word,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output ntm_pkg::out_word_t                   out_word,
    input  logic                                 cfg_wr_en,
    input  logic [ntm_pkg::NUM_STATES_W-1:0]     cfg_wr_data
);

    localparam int SW = $clog2(NUM_STATES);
    localparam int NW = $clog2(NUM_STATES + 1);
    localparam int AW = SW + SYMBOL_BITS;

    typedef enum logic [6:0] {
        ST_CLEAR    = 7'b0000001,
        ST_IDLE     = 7'b0000010,
        ST_LOAD_RD  = 7'b0000100,
        ST_LOAD_WR  = 7'b0001000,
        ST_FEED     = 7'b0010000,
        ST_FEED_END = 7'b0100000,
        ST_FIN      = 7'b1000000
    } state_t;

    state_t                           state_reg;
    state_t                           state_next;
    logic [ntm_pkg::NUM_STATES_W-1:0] num_states_reg;
    logic [NUM_STATES-1:0]            active_reg;
    logic [NUM_STATES-1:0]            active_next;
    logic                             alive_reg;
    logic                             alive_next;
    logic [NUM_STATES-1:0]            acc_reg;
    logic [NUM_STATES-1:0]            acc_next;
    logic                             pend_reg;
    logic                             pend_next;
    logic [SW-1:0]                    scan_reg;
    logic [SW-1:0]                    scan_next;
    logic [SW-1:0]                    from_reg;
    logic [SW-1:0]                    from_next;
    logic [SYMBOL_BITS-1:0]           sym_reg;
    logic [SYMBOL_BITS-1:0]           sym_next;
    logic [NUM_STATES-1:0]            to_mask_reg;
    logic [NUM_STATES-1:0]            to_mask_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    ntm_pkg::out_word_t               out_word_reg;
    ntm_pkg::out_word_t               out_word_next;

    logic [NW-1:0]                    n_use;
    logic [SW-1:0]                    last_idx;
    logic [NUM_STATES-1:0]            use_mask;
    logic [NUM_STATES-1:0]            cur_set;
    logic [NUM_STATES-1:0]            rd_data;
    logic [NUM_STATES-1:0]            feed_set;
    logic                             store_busy;
    ntm_pkg::store_op_t               store_op;
    logic [AW-1:0]                    store_addr;
    logic                             in_accept;
    logic                             out_free;
    logic                             edge_ok;

    // states in use, clamped to 1..NUM_STATES
    always_comb
    begin
        if (num_states_reg == '0)
        begin
            n_use = NW'(1);
        end
        else if (32'(num_states_reg) > 32'(NUM_STATES))
        begin
            n_use = NW'(NUM_STATES);
        end
        else
        begin
            n_use = NW'(num_states_reg);
        end
    end

    assign last_idx = SW'(n_use - NW'(1));

    always_comb
    begin
        for (int i = 0; i < NUM_STATES; i++)
        begin
            use_mask[i] = (32'(i) < 32'(n_use));
        end
    end

    assign cur_set   = active_reg & use_mask;
    assign feed_set  = (acc_reg | (pend_reg ? rd_data : '0)) & use_mask;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign edge_ok   = (32'(in_word.from_state) < 32'(NUM_STATES))
                    && (32'(in_word.to_state) < 32'(NUM_STATES));

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        alive_next     = alive_reg;
        acc_next       = acc_reg;
        pend_next      = 1'b0;
        scan_next      = scan_reg;
        from_next      = from_reg;
        sym_next       = sym_reg;
        to_mask_next   = to_mask_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        store_op       = '0;
        store_addr     = {from_reg, sym_reg};

        unique case (state_reg)
            ST_CLEAR:
            begin
                if (!store_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    sym_next     = in_word.symbol[SYMBOL_BITS-1:0];
                    from_next    = SW'(in_word.from_state);
                    to_mask_next = NUM_STATES'(1) << in_word.to_state;
                    scan_next    = '0;
                    acc_next     = '0;
                    unique case (in_word.operation)
                        ntm_pkg::OP_LOAD:
                        begin
                            if (edge_ok)
                            begin
                                state_next = ST_LOAD_RD;
                            end
                        end
                        ntm_pkg::OP_START:
                        begin
                            active_next = NUM_STATES'(1);
                            alive_next  = 1'b1;
                            state_next  = ST_FIN;
                        end
                        ntm_pkg::OP_FEED:
                        begin
                            state_next = alive_reg ? ST_FEED : ST_FIN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOAD_RD:
            begin
                store_op.rd_en = 1'b1;
                state_next     = ST_LOAD_WR;
            end
            ST_LOAD_WR:
            begin
                store_op.set_en = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_FEED:
            begin
                store_op.rd_en = 1'b1;
                store_addr     = {scan_reg, sym_reg};
                pend_next      = cur_set[scan_reg];
                acc_next       = acc_reg | (pend_reg ? rd_data : '0);
                scan_next      = scan_reg + SW'(1);
                if (scan_reg == last_idx)
                begin
                    state_next = ST_FEED_END;
                end
            end
            ST_FEED_END:
            begin
                active_next = feed_set;
                if (feed_set == '0)
                begin
                    alive_next = 1'b0;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_word_next.alive    = alive_reg;
                    out_word_next.accepted = alive_reg && active_reg[last_idx];
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            num_states_reg <= ntm_pkg::NUM_STATES_W'(2);
            active_reg     <= NUM_STATES'(1);
            alive_reg      <= 1'b1;
            pend_reg       <= 1'b0;
            scan_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            alive_reg     <= alive_next;
            pend_reg      <= pend_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                num_states_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        from_reg     <= from_next;
        sym_reg      <= sym_next;
        to_mask_reg  <= to_mask_next;
        out_word_reg <= out_word_next;
    end

    ntm_store #(
        .NUM_STATES  (NUM_STATES),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (store_op),
        .addr     (store_addr),
        .set_mask (to_mask_reg),
        .rd_data  (rd_data),
        .busy     (store_busy)
    );

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_stall_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
        store_busy |-> (in_stall && (state_reg == ST_CLEAR)))
        else $error("input open during clearing pass");

    a_dead_run_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !alive_reg |-> (active_reg == '0))
        else $error("dead run keeps active states");

    a_accept_needs_alive : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_word_reg.alive || !out_word_reg.accepted))
        else $error("accepted reported on a dead run");

    a_fin_holds_result : assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIN) && out_valid_reg && out_stall) |=> (state_reg == ST_FIN))
        else $error("result dropped while output register full");

endmodule

>>> rtl/ntm_store.sv
// transition store: one mask per (state, symbol) with clearing pass and edge set
module ntm_store #(
    parameter int NUM_STATES  = 16,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  ntm_pkg::store_op_t                           op,
    input  logic [$clog2(NUM_STATES)+SYMBOL_BITS-1:0]    addr,
    input  logic [NUM_STATES-1:0]                        set_mask,
    output logic [NUM_STATES-1:0]                        rd_data,
    output logic                                         busy
);

    localparam int AW    = $clog2(NUM_STATES) + SYMBOL_BITS;
    localparam int DEPTH = NUM_STATES << SYMBOL_BITS;

    logic [NUM_STATES-1:0] mem [DEPTH];
    logic [NUM_STATES-1:0] rd_data_reg;
    logic [AW-1:0]         clr_addr_reg;
    logic [AW-1:0]         clr_addr_next;
    logic                  clearing_reg;
    logic                  clearing_next;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clearing_reg <= clearing_next;
        end
    end

    // set_en follows a read of the same entry, so rd_data_reg holds its old mask
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (op.set_en)
        begin
            mem[addr] <= rd_data_reg | set_mask;
        end
        if (op.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

    a_set_after_read : assert property (@(posedge clk) disable iff (!rst_n)
        op.set_en |-> ($past(op.rd_en) && ($past(addr) == addr)))
        else $error("edge set without a read of the same entry");

    a_no_set_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (!op.set_en && !op.rd_en))
        else $error("store access during clearing pass");

    a_clear_ends : assert property (@(posedge clk) disable iff (!rst_n)
        (clearing_reg && (clr_addr_reg == AW'(DEPTH - 1))) |=> !clearing_reg)
        else $error("clearing pass does not end at last entry");

endmodule

>>> dv/nfa_token_matcher_tb.sv
// self-checking testbench of the nfa token matcher with its own automaton predictor
module nfa_token_matcher_tb;

    localparam int MAX_STATES = 16;
    localparam int SYM_BITS = 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS = 10;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    ntm_pkg::in_word_t in_word = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    ntm_pkg::out_word_t out_word;
    logic cfg_wr_en = 1'b0;
    logic [ntm_pkg::NUM_STATES_W-1:0] cfg_wr_data = '0;

    logic [MAX_STATES-1:0] dest_masks [0:(MAX_STATES << SYM_BITS)-1];
    logic [MAX_STATES-1:0] active_set;
    logic run_alive;
    logic [ntm_pkg::NUM_STATES_W-1:0] num_states;
    ntm_pkg::out_word_t expected_reports [$];
    logic [7:0] alphabet [4];
    logic [ntm_pkg::NUM_STATES_W-1:0] config_plan [9] =
        '{5'd16, 5'd3, 5'd31, 5'd0, 5'd5, 5'd17, 5'd8, 5'd1, 5'd12};
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int cycle_count = 0;

    nfa_token_matcher dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin : check_reports
        ntm_pkg::out_word_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: alive=%0b accepted=%0b",
                             out_word.alive, out_word.accepted);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (out_word.alive !== want.alive || out_word.accepted !== want.accepted)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: expected alive=%0b accepted=%0b, ",
                                  "got alive=%0b accepted=%0b"},
                                 want.alive, want.accepted, out_word.alive, out_word.accepted);
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic void reset_automaton();
        for (int i = 0; i < (MAX_STATES << SYM_BITS); i++)
            dest_masks[i] = '0;
        active_set = 1;
        run_alive = 1'b1;
        num_states = 2;
    endfunction

    function automatic int states_used();
        if (num_states == 0)
            return 1;
        if (num_states > MAX_STATES)
            return MAX_STATES;
        return int'(num_states);
    endfunction

    function automatic void step_automaton(ntm_pkg::in_word_t w);
        logic [MAX_STATES-1:0] in_use;
        logic [MAX_STATES-1:0] next_set;
        ntm_pkg::out_word_t rep;
        int n;
        n = states_used();
        in_use = '0;
        for (int s = 0; s < n; s++)
            in_use[s] = 1'b1;
        next_set = '0;
        case (w.operation)
            ntm_pkg::OP_LOAD:
                dest_masks[{w.from_state, w.symbol}][w.to_state] = 1'b1;
            ntm_pkg::OP_START:
            begin
                active_set = 1;
                run_alive = 1'b1;
            end
            ntm_pkg::OP_FEED:
            begin
                if (run_alive)
                begin
                    for (int s = 0; s < n; s++)
                        if (active_set[s])
                            next_set |= dest_masks[{4'(s), w.symbol}];
                    next_set &= in_use;
                    active_set = next_set;
                    if (next_set == 0)
                        run_alive = 1'b0;
                end
            end
            default:
                ;
        endcase
        if (w.operation == ntm_pkg::OP_START || w.operation == ntm_pkg::OP_FEED)
        begin
            rep.alive = run_alive;
            rep.accepted = run_alive && active_set[n-1];
            expected_reports.push_back(rep);
        end
    endfunction

    function automatic ntm_pkg::in_word_t word_of(logic [1:0] op, logic [7:0] sym,
                                                  int from, int to);
        ntm_pkg::in_word_t w;
        w.operation = op;
        w.symbol = sym;
        w.from_state = 4'(from);
        w.to_state = 4'(to);
        return w;
    endfunction

    task automatic send_word(input ntm_pkg::in_word_t w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        step_automaton(w);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_num_states(input logic [ntm_pkg::NUM_STATES_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        num_states = value;
    endtask

    task automatic test_reset_state();
        send_word(word_of(ntm_pkg::OP_FEED, 8'h00, 0, 0));
        send_word(word_of(ntm_pkg::OP_FEED, 8'hff, 15, 15));
        send_word(word_of(ntm_pkg::OP_START, 8'h00, 0, 0));
    endtask

    task automatic test_edge_loading();
        send_word(word_of(ntm_pkg::OP_LOAD, 8'hff, 0, 1));
        send_word(word_of(ntm_pkg::OP_LOAD, 8'hff, 0, 1));
        send_word(word_of(ntm_pkg::OP_LOAD, 8'h00, 1, 1));
        send_word(word_of(ntm_pkg::OP_LOAD, 8'ha5, 15, 15));
        send_word(word_of(OP_UNUSED, 8'hff, 15, 15));
        send_word(word_of(ntm_pkg::OP_START, 8'h00, 0, 0));
        send_word(word_of(ntm_pkg::OP_FEED, 8'hff, 0, 0));
        send_word(word_of(ntm_pkg::OP_FEED, 8'h00, 0, 0));
        send_word(word_of(ntm_pkg::OP_FEED, 8'h00, 0, 0));
        send_word(word_of(ntm_pkg::OP_FEED, 8'h5a, 0, 0));
    endtask

    task automatic test_single_state();
        wait_idle();
        write_num_states(5'd1);
        send_word(word_of(ntm_pkg::OP_START, 8'h00, 0, 0));
        send_word(word_of(ntm_pkg::OP_LOAD, 8'h3c, 0, 0));
        send_word(word_of(ntm_pkg::OP_FEED, 8'h3c, 0, 0));
        send_word(word_of(ntm_pkg::OP_LOAD, 8'hc3, 0, 1));
        send_word(word_of(ntm_pkg::OP_FEED, 8'hc3, 0, 0));
    endtask

    task automatic test_register_range();
        wait_idle();
        write_num_states(5'd0);
        send_word(word_of(ntm_pkg::OP_START, 8'h00, 0, 0));
        wait_idle();
        write_num_states(5'd31);
        send_word(word_of(ntm_pkg::OP_START, 8'h00, 0, 0));
        send_word(word_of(ntm_pkg::OP_FEED, 8'hff, 0, 0));
    endtask

    task automatic run_automaton(input logic [ntm_pkg::NUM_STATES_W-1:0] setting);
        int n;
        int len;
        logic [7:0] sym;
        wait_idle();
        write_num_states(setting);
        n = states_used();
        for (int k = 0; k < 4; k++)
            alphabet[k] = 8'($urandom_range(255));
        // chain so the accepting state is reachable
        for (int k = 0; k < n - 1; k++)
            send_word(word_of(ntm_pkg::OP_LOAD, alphabet[$urandom_range(3)], k, k + 1));
        for (int k = 0; k < n + 4; k++)
        begin
            if ($urandom_range(9) == 0)
                send_word(word_of(ntm_pkg::OP_LOAD, 8'($urandom), $urandom_range(15),
                                  $urandom_range(15)));
            else
                send_word(word_of(ntm_pkg::OP_LOAD, alphabet[$urandom_range(3)],
                                  $urandom_range(n - 1), $urandom_range(n - 1)));
        end
        for (int k = 0; k < 14; k++)
        begin
            if (k == 7)
                wait_idle();
            send_word(word_of(ntm_pkg::OP_START, 8'($urandom), $urandom_range(15),
                              $urandom_range(15)));
            len = $urandom_range(1, 8);
            repeat (len)
            begin
                if ($urandom_range(19) == 0)
                    send_word(18'($urandom));
                else
                begin
                    sym = ($urandom_range(14) == 0) ? 8'($urandom) : alphabet[$urandom_range(3)];
                    send_word(word_of(ntm_pkg::OP_FEED, sym, $urandom_range(15),
                                      $urandom_range(15)));
                end
            end
        end
    endtask

    task automatic test_random_traffic(input int s_pct, input int r_pct, input int first);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int p = 0; p < 3; p++)
            run_automaton(config_plan[first + p]);
    endtask

    initial
    begin
        reset_automaton();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_edge_loading();
        test_single_state();
        test_register_range();
        test_random_traffic(25, 64, 0);
        test_random_traffic(64, 25, 3);
        test_random_traffic(0, 0, 6);
        wait_idle();
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
